### hw/rtl/isr_pkg.sv
// Shared types, widths and constants for the isometric segment rasterizer.
// Used by isr_divider and isometric_segment_rasterizer_top; depends on nothing.
package isr_pkg;

  // Grid and emission limits
  localparam int GRID_SIDE_DEF = 256;
  localparam int MAX_PIXELS    = 64;
  localparam int PIX_CNT_W     = $clog2(MAX_PIXELS);

  // Projection coefficients, cos(0.7) and sin(0.7) in Q.8
  localparam int COS_Q8 = 196;
  localparam int SIN_Q8 = 165;

  // Fixed-point formats
  localparam int FRAC_W   = 16;           // fraction bits of the DDA position
  localparam int ONE_Q16  = 65536;
  localparam int PIX_Q8   = 256;          // one pixel in Q.8
  localparam int P8W      = 26;           // projected endpoint, signed Q.8
  localparam int D_W      = 16;           // endpoint difference, signed Q.8
  localparam int MAG_W    = 15;           // magnitude of a difference
  localparam int QUO_W    = FRAC_W + 1;   // step magnitude, up to one pixel
  localparam int STEP_W   = QUO_W + 1;    // signed step
  localparam int POS_W    = P8W + 10;     // signed Q.16 position
  localparam int DIFF_W   = 26;           // signed Q.16 distance to the end point
  localparam int PIX_W    = 15;           // screen coordinate

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ZOOM_W     = 6;
  localparam int SHIFT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 2'd2;

  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 6'd20;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PROJ,
    ST_SETUP,
    ST_DIV,
    ST_STEP
  } isr_state_t;

endpackage

### hw/rtl/isr_divider.sv
// Iterative restoring divider that computes (numer * 2^16) / denom, one bit a cycle.
// Depends on isr_pkg for widths; the numerator never exceeds the denominator.
module isr_divider import isr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] numer,
  input  logic [MAG_W-1:0] denom,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int REM_W = MAG_W + 2;
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic [REM_W-1:0] rem_r;
  logic [MAG_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] trial;
  logic             ge;
  logic [REM_W-1:0] rem_keep;

  // Trial subtraction: the sign bit tells whether the divisor fits.
  assign trial    = rem_r - REM_W'(den_r);
  assign ge       = ~trial[REM_W-1];
  assign rem_keep = ge ? trial : rem_r;

  // Control: busy for one cycle per quotient bit, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LAST;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: shift in zeros below the numerator, collect quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(numer);
      den_r <= denom;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_keep[REM_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/isometric_segment_rasterizer_top.sv
// Isometric wireframe edge rasterizer: projects one grid edge and walks it with a DDA.
// Depends on isr_pkg and instantiates isr_divider for the minor-axis step.
//
// Each input item is one grid edge; it yields up to 64 pixel items, the final one
// flagged by last_pixel. An edge is taken in the idle state, then goes through
// scaling, projection and setup states and waits in the divide state for the
// bit-serial divider and its done pulse; then it emits one pixel per cycle while
// the output side takes them. An edge that leaves the grid or spans less than one
// pixel produces no item and returns to idle from the setup state. The input is
// ready only between edges; a pixel waiting in the output register does not hold
// off the next edge. Configuration writes take effect at once.
module isometric_segment_rasterizer_top import isr_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // Edge input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_start_col,
  input  logic [7:0]               in_start_row,
  input  logic                     in_direction,
  input  logic signed [5:0]        in_height_start,
  input  logic signed [5:0]        in_height_end,
  // Pixel output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PIX_W-1:0]  out_pixel_x,
  output logic signed [PIX_W-1:0]  out_pixel_y,
  output logic                     out_raised,
  output logic                     out_last_pixel
);

  localparam logic [12:0] GRID_LIM = 13'(GRID_SIDE);
  localparam logic signed [P8W-1:0] COS_K = P8W'(COS_Q8);
  localparam logic signed [P8W-1:0] SIN_K = P8W'(SIN_Q8);
  localparam logic [MAG_W-1:0] MIN_SPAN = MAG_W'(PIX_Q8);
  localparam logic [QUO_W-1:0] ONE_MAG = QUO_W'(ONE_Q16);
  localparam logic signed [STEP_W-1:0] STEP_MAX = STEP_W'(ONE_Q16);
  localparam logic [PIX_CNT_W-1:0] CNT_LAST = PIX_CNT_W'(MAX_PIXELS - 1);

  // Truncate a Q.16 position toward zero and keep the screen coordinate bits.
  function automatic logic [PIX_W-1:0] trunc_pix(input logic signed [POS_W-1:0] v);
    logic inc;
    inc = v[POS_W-1] && (v[FRAC_W-1:0] != '0);
    return v[FRAC_W+PIX_W-1:FRAC_W] + PIX_W'(inc);
  endfunction

  // True when a Q.16 distance truncates to zero whole pixels.
  function automatic logic at_end(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-FRAC_W-1:0] upper;
    upper = v[DIFF_W-1:FRAC_W];
    return (upper == '0) || ((upper == '1) && (v[FRAC_W-1:0] != '0));
  endfunction

  // Configuration registers
  logic [ZOOM_W-1:0]  zoom_r;
  logic [SHIFT_W-1:0] shift_x_r;
  logic [SHIFT_W-1:0] shift_y_r;

  // Sequencer
  isr_state_t state_r;
  isr_state_t state_nxt;
  logic       emit_en;
  logic       div_start;
  logic       div_done;
  logic [QUO_W-1:0] div_quo;

  // Latched edge
  logic [7:0]        col_r;
  logic [7:0]        row_r;
  logic              dir_r;
  logic signed [5:0] h0_r;
  logic signed [5:0] h1_r;

  // Scaling and projection
  logic signed [8:0]  cr_diff;
  logic signed [15:0] scale_diff;
  logic [14:0]        scale_sum;
  logic [12:0]        col_end;
  logic [12:0]        row_end;
  logic signed [6:0]  h_diff;
  logic signed [15:0] a_r;
  logic [14:0]        b_r;
  logic [13:0]        zc_r;
  logic [13:0]        zs_r;
  logic               off_r;
  logic signed [P8W-1:0] x0_r;
  logic signed [P8W-1:0] y0_r;
  logic signed [D_W-1:0] dx_r;
  logic signed [D_W-1:0] dy_r;

  // Setup
  logic signed [D_W-1:0] dx_neg;
  logic signed [D_W-1:0] dy_neg;
  logic [MAG_W-1:0]      abs_dx;
  logic [MAG_W-1:0]      abs_dy;
  logic                  x_major;
  logic [MAG_W-1:0]      span_max;
  logic [MAG_W-1:0]      span_min;
  logic                  too_short;
  logic                  x_major_r;

  // DDA
  logic [QUO_W-1:0]         mag_x;
  logic [QUO_W-1:0]         mag_y;
  logic signed [STEP_W-1:0] stx_v;
  logic signed [STEP_W-1:0] sty_v;
  logic signed [STEP_W-1:0] stx_r;
  logic signed [STEP_W-1:0] sty_r;
  logic signed [POS_W-1:0]  px_r;
  logic signed [POS_W-1:0]  py_r;
  logic signed [DIFF_W-1:0] diffx_r;
  logic signed [DIFF_W-1:0] diffy_r;
  logic signed [DIFF_W-1:0] diffx_next;
  logic signed [DIFF_W-1:0] diffy_next;
  logic [PIX_CNT_W-1:0]     cnt_r;
  logic                     last_v;

  // Output register
  logic                    out_valid_r;
  logic                    out_free;
  logic [PIX_W-1:0]        pix_x_r;
  logic [PIX_W-1:0]        pix_y_r;
  logic                    raised_r;
  logic                    last_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r    <= ZOOM_RESET;
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZOOM:    zoom_r    <= cfg_data[ZOOM_W-1:0];
        REG_SHIFT_X: shift_x_r <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_PROJ;
      ST_PROJ:  state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = too_short ? ST_IDLE : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_STEP;
      ST_STEP:  if (emit_en && last_v) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    emit_en   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_SETUP: div_start = ~too_short;
      ST_STEP:  emit_en   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scale the start point by zoom and check both ends against the grid.
  assign cr_diff    = $signed({1'b0, col_r}) - $signed({1'b0, row_r});
  assign scale_diff = 16'(cr_diff) * 16'($signed({1'b0, zoom_r}));
  assign scale_sum  = (15'(col_r) + 15'(row_r)) * 15'(zoom_r);
  assign col_end    = 13'(col_r) + (dir_r ? 13'd0 : 13'd1);
  assign row_end    = 13'(row_r) + (dir_r ? 13'd1 : 13'd0);
  assign h_diff     = 7'(h1_r) - 7'(h0_r);

  // Magnitudes of the edge and the choice of major axis.
  assign dx_neg    = -dx_r;
  assign dy_neg    = -dy_r;
  assign abs_dx    = dx_r[D_W-1] ? dx_neg[MAG_W-1:0] : dx_r[MAG_W-1:0];
  assign abs_dy    = dy_r[D_W-1] ? dy_neg[MAG_W-1:0] : dy_r[MAG_W-1:0];
  assign x_major   = abs_dx >= abs_dy;
  assign span_max  = x_major ? abs_dx : abs_dy;
  assign span_min  = x_major ? abs_dy : abs_dx;
  assign too_short = off_r || (span_max < MIN_SPAN);

  // Steps: the major axis moves one whole pixel, the minor one by the quotient.
  assign mag_x = x_major_r ? ONE_MAG : div_quo;
  assign mag_y = x_major_r ? div_quo : ONE_MAG;
  assign stx_v = dx_r[D_W-1] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
  assign sty_v = dy_r[D_W-1] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});

  // The current pixel is the last when the next position reaches the end point or it is the 64th.
  assign diffx_next = diffx_r + DIFF_W'(stx_r);
  assign diffy_next = diffy_r + DIFF_W'(sty_r);
  assign last_v     = (cnt_r == CNT_LAST) || (at_end(diffx_next) && at_end(diffy_next));

  isr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (span_min),
    .denom    (span_max),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Edge datapath, advanced one stage per sequencer state.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r <= in_start_col;
        row_r <= in_start_row;
        dir_r <= in_direction;
        h0_r  <= in_height_start;
        h1_r  <= in_height_end;
      end
      ST_SCALE: begin
        a_r   <= scale_diff;
        b_r   <= scale_sum;
        zc_r  <= 14'(zoom_r) * 14'(COS_Q8);
        zs_r  <= 14'(zoom_r) * 14'(SIN_Q8);
        off_r <= (col_end >= GRID_LIM) || (row_end >= GRID_LIM);
      end
      ST_PROJ: begin
        x0_r <= P8W'(a_r) * COS_K + $signed(P8W'({shift_x_r, 8'h00}));
        y0_r <= $signed(P8W'(b_r)) * SIN_K - (P8W'(h0_r) <<< 8)
                + $signed(P8W'({shift_y_r, 8'h00}));
        dx_r <= dir_r ? -$signed({2'b00, zc_r}) : $signed({2'b00, zc_r});
        dy_r <= $signed({2'b00, zs_r}) - (D_W'(h_diff) <<< 8);
      end
      ST_SETUP: begin
        x_major_r <= x_major;
        px_r      <= POS_W'(x0_r) <<< 8;
        py_r      <= POS_W'(y0_r) <<< 8;
        diffx_r   <= -(DIFF_W'(dx_r) <<< 8);
        diffy_r   <= -(DIFF_W'(dy_r) <<< 8);
        cnt_r     <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          stx_r <= stx_v;
          sty_r <= sty_v;
        end
      end
      ST_STEP: begin
        if (emit_en) begin
          px_r    <= px_r + POS_W'(stx_r);
          py_r    <= py_r + POS_W'(sty_r);
          diffx_r <= diffx_next;
          diffy_r <= diffy_next;
          cnt_r   <= cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: a new pixel item loads when the slot is empty or being taken.
  assign out_free = ~out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      pix_x_r  <= trunc_pix(px_r);
      pix_y_r  <= trunc_pix(py_r);
      raised_r <= (h0_r != '0) || (h1_r != '0);
      last_r   <= last_v;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = $signed(pix_x_r);
  assign out_pixel_y    = $signed(pix_y_r);
  assign out_raised     = raised_r;
  assign out_last_pixel = last_r;

`ifndef NO_ASSERTIONS
  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  // Loading the final pixel of an edge returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_en && last_v) |=> state_r == ST_IDLE)
    else $error("sequencer kept stepping after the last pixel");

  // No DDA step ever exceeds one whole pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> (stx_r <= STEP_MAX && stx_r >= -STEP_MAX
                            && sty_r <= STEP_MAX && sty_r >= -STEP_MAX))
    else $error("DDA step larger than one pixel");

  // When x is the major axis, the x step is always exactly one pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && x_major_r) |-> (stx_r == STEP_MAX || stx_r == -STEP_MAX))
    else $error("major-axis step is not one pixel");
`endif

endmodule
